### sv/utf8c_pkg.sv
// ----------------------------------------------------------------------------
// utf8c_pkg: shared types and constants of the UTF-8 codec
// Word layouts of the request channel and of the result burst that travels
// from the processing stage to the output serialiser.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8c_pkg;

   // Operation codes carried in the func field.
   localparam logic FUNC_ENCODE = 1'b0;
   localparam logic FUNC_DECODE = 1'b1;

   // Largest code point that may be encoded.
   localparam logic [20:0] MAX_POINT = 21'h10FFFF;

   // Range limits of the one, two and three byte forms.
   localparam logic [20:0] LIMIT_ONE   = 21'h00007F;
   localparam logic [20:0] LIMIT_TWO   = 21'h0007FF;
   localparam logic [20:0] LIMIT_THREE = 21'h00FFFF;

   // Length prefixes of lead and continuation bytes.
   localparam logic [2:0] LEAD_TWO   = 3'b110;
   localparam logic [3:0] LEAD_THREE = 4'b1110;
   localparam logic [4:0] LEAD_FOUR  = 5'b11110;
   localparam logic [1:0] CONT_MARK  = 2'b10;

   // One request word as held in the input register.
   typedef struct packed {
      logic        func;
      logic [20:0] code_point;
      logic [7:0]  in_byte;
      logic        string_start;
      logic        string_end;
   } req_word_type;

   // All results caused by one request word.
   typedef struct packed {
      logic            has_result;
      logic [1:0]      count_m1;
      logic [3:0][7:0] bytes;
      logic [20:0]     point;
      logic            error;
   } burst_type;

endpackage

`default_nettype wire

### sv/utf8c_req_if.sv
// ----------------------------------------------------------------------------
// utf8c_req_if: request channel of the UTF-8 codec
// Valid/ready channel carrying one code point or one string byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8c_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [20:0] code_point;
   logic [7:0]  in_byte;
   logic        string_start;
   logic        string_end;

   modport source (
      output valid, func, code_point, in_byte, string_start, string_end,
      input  ready
   );

   modport sink (
      input  valid, func, code_point, in_byte, string_start, string_end,
      output ready
   );
endinterface

`default_nettype wire

### sv/utf8c_rsp_if.sv
// ----------------------------------------------------------------------------
// utf8c_rsp_if: result channel of the UTF-8 codec
// Valid/ready channel carrying one encoded byte or one decode result per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8c_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic [20:0] decoded_point;
   logic        error;
   logic        last;

   modport source (
      output valid, out_byte, decoded_point, error, last,
      input  ready
   );

   modport sink (
      input  valid, out_byte, decoded_point, error, last,
      output ready
   );
endinterface

`default_nettype wire

### sv/utf8c_input_stage.sv
// ----------------------------------------------------------------------------
// utf8c_input_stage: request input register
// Captures one request word and holds it until the processing stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8c_input_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   utf8c_req_if.sink              req,
   input  wire logic              take,
   output logic                   word_valid,
   output utf8c_pkg::req_word_type word
);
   import utf8c_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_word_type word_ff;
   logic         accept;

   // A new word may enter when the register is empty or is emptied now.
   assign req.ready = !valid_ff || take;
   assign accept    = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // The payload register needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff.func         <= req.func;
         word_ff.code_point   <= req.code_point;
         word_ff.in_byte      <= req.in_byte;
         word_ff.string_start <= req.string_start;
         word_ff.string_end   <= req.string_end;
      end
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;
endmodule

`default_nettype wire

### sv/utf8c_process.sv
// ----------------------------------------------------------------------------
// utf8c_process: encode and decode logic with the decoder state
// Turns the held request word into a burst of results and advances the
// decoder state when the word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8c_process (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               take,
   input  wire utf8c_pkg::req_word_type word,
   output utf8c_pkg::burst_type    burst
);
   import utf8c_pkg::*;

   logic [1:0]  bytes_left_ff;
   logic [1:0]  bytes_left_in;
   logic [20:0] accumulator_ff;
   logic [20:0] accumulator_in;
   logic        char_done_ff;
   logic        char_done_in;

   burst_type   enc_burst;
   burst_type   dec_burst;

   // Encoder: split the code point into its one to four bytes, or flag a point above MAX_POINT as an error.
   always_comb begin
      logic [20:0] cp;
      cp = word.code_point;
      enc_burst            = '0;
      enc_burst.has_result = 1'b1;
      if (cp > MAX_POINT) begin
         enc_burst.error = 1'b1;
      end else if (cp <= LIMIT_ONE) begin
         enc_burst.count_m1 = 2'd0;
         enc_burst.bytes[0] = {1'b0, cp[6:0]};
      end else if (cp <= LIMIT_TWO) begin
         enc_burst.count_m1 = 2'd1;
         enc_burst.bytes[0] = {LEAD_TWO, cp[10:6]};
         enc_burst.bytes[1] = {CONT_MARK, cp[5:0]};
      end else if (cp <= LIMIT_THREE) begin
         enc_burst.count_m1 = 2'd2;
         enc_burst.bytes[0] = {LEAD_THREE, cp[15:12]};
         enc_burst.bytes[1] = {CONT_MARK, cp[11:6]};
         enc_burst.bytes[2] = {CONT_MARK, cp[5:0]};
      end else begin
         enc_burst.count_m1 = 2'd3;
         enc_burst.bytes[0] = {LEAD_FOUR, cp[20:18]};
         enc_burst.bytes[1] = {CONT_MARK, cp[17:12]};
         enc_burst.bytes[2] = {CONT_MARK, cp[11:6]};
         enc_burst.bytes[3] = {CONT_MARK, cp[5:0]};
      end
   end

   // Decoder: one string byte against the current character state.
   always_comb begin
      logic [7:0]  b;
      logic [20:0] acc_shift;
      logic [1:0]  left_dec;
      b         = word.in_byte;
      acc_shift = {accumulator_ff[14:0], b[5:0]};
      left_dec  = bytes_left_ff - 2'd1;

      bytes_left_in  = bytes_left_ff;
      accumulator_in = accumulator_ff;
      char_done_in   = char_done_ff;
      dec_burst      = '0;

      if (word.string_start) begin
         // Lead byte sets the sequence length.
         unique case (b) inside
            8'b0???_????: begin
               char_done_in         = 1'b1;
               bytes_left_in        = 2'd0;
               accumulator_in       = {13'd0, b};
               dec_burst.has_result = 1'b1;
               dec_burst.point      = {13'd0, b};
            end
            8'b110?_????, 8'b1110_????, 8'b1111_0???: begin
               if (b[5] == 1'b0) begin
                  bytes_left_in  = 2'd1;
                  accumulator_in = {16'd0, b[4:0]};
               end else if (b[4] == 1'b0) begin
                  bytes_left_in  = 2'd2;
                  accumulator_in = {17'd0, b[3:0]};
               end else begin
                  bytes_left_in  = 2'd3;
                  accumulator_in = {18'd0, b[2:0]};
               end
               char_done_in = 1'b0;
               // A multi-byte lead that also ends the string is short.
               if (word.string_end) begin
                  char_done_in         = 1'b1;
                  bytes_left_in        = 2'd0;
                  dec_burst.has_result = 1'b1;
                  dec_burst.error      = 1'b1;
               end
            end
            default: begin
               char_done_in         = 1'b1;
               bytes_left_in        = 2'd0;
               dec_burst.has_result = 1'b1;
               dec_burst.error      = 1'b1;
            end
         endcase
      end else if (!char_done_ff) begin
         if (b[7:6] != CONT_MARK) begin
            // Bad continuation byte.
            char_done_in         = 1'b1;
            bytes_left_in        = 2'd0;
            dec_burst.has_result = 1'b1;
            dec_burst.error      = 1'b1;
         end else begin
            accumulator_in = acc_shift;
            bytes_left_in  = left_dec;
            if (left_dec == 2'd0) begin
               char_done_in         = 1'b1;
               dec_burst.has_result = 1'b1;
               dec_burst.point      = acc_shift;
            end else if (word.string_end) begin
               char_done_in         = 1'b1;
               bytes_left_in        = 2'd0;
               dec_burst.has_result = 1'b1;
               dec_burst.error      = 1'b1;
            end
         end
      end
   end

   // Decoder state moves only on decode words that are taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff  <= 2'd0;
         accumulator_ff <= 21'd0;
         char_done_ff   <= 1'b1;
      end else if (take && word.func == FUNC_DECODE) begin
         bytes_left_ff  <= bytes_left_in;
         accumulator_ff <= accumulator_in;
         char_done_ff   <= char_done_in;
      end
   end

   assign burst = (word.func == FUNC_ENCODE) ? enc_burst : dec_burst;
endmodule

`default_nettype wire

### sv/utf8c_output_stage.sv
// ----------------------------------------------------------------------------
// utf8c_output_stage: result register and byte serialiser
// Holds one burst of results and hands them out one word per cycle while rsp.ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8c_output_stage (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            load,
   input  wire utf8c_pkg::burst_type burst,
   output logic                 can_load,
   utf8c_rsp_if.source          rsp
);
   import utf8c_pkg::*;

   logic            busy_ff;
   logic            busy_in;
   logic [1:0]      count_ff;
   logic [3:0][7:0] bytes_ff;
   logic [20:0]     point_ff;
   logic            error_ff;
   logic            emit;
   logic            final_word;

   assign emit       = busy_ff && rsp.ready;
   assign final_word = emit && (count_ff == 2'd0);
   assign can_load   = !busy_ff || final_word;

   always_comb begin
      busy_in = busy_ff;
      if (load) begin
         busy_in = 1'b1;
      end else if (final_word) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // Load a new burst, or shift the next byte to the front.
   always_ff @(posedge clock) begin
      if (load) begin
         count_ff <= burst.count_m1;
         bytes_ff <= burst.bytes;
         point_ff <= burst.point;
         error_ff <= burst.error;
      end else if (emit && count_ff != 2'd0) begin
         count_ff <= count_ff - 2'd1;
         bytes_ff <= {8'd0, bytes_ff[3:1]};
      end
   end

   assign rsp.valid         = busy_ff;
   assign rsp.out_byte      = bytes_ff[0];
   assign rsp.decoded_point = point_ff;
   assign rsp.error         = error_ff;
   assign rsp.last          = (count_ff == 2'd0);
endmodule

`default_nettype wire

### sv/utf8_codec.sv
// ----------------------------------------------------------------------------
// utf8_codec: two-direction UTF-8 codec
// Encodes code points into UTF-8 bytes and decodes the first character of
// a byte string.
//
//   Channel   Direction   Word carries
//   req_chan  in          func, code_point, in_byte, string_start, string_end
//   rsp_chan  out         out_byte, decoded_point, error, last
//
// A decode word gives at most one result word; an encode word gives one to
// four result words, one per cycle while rsp_chan.ready stays high. An
// accepted word passes through the input register and the result register
// before its first result appears. Reset clears the handshake state, empties
// both registers and sets the decoder to no character in progress. A stall
// on the result channel holds the current word and, once both registers are
// full, drops req_chan.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_codec (
   input  wire logic   clock,
   input  wire logic   reset,
   utf8c_req_if.sink   req_chan,
   utf8c_rsp_if.source rsp_chan
);
   import utf8c_pkg::*;

   logic         word_valid;
   req_word_type word;
   burst_type    burst;
   logic         can_load;
   logic         take;
   logic         load;

   // A word with no result leaves at once; others wait for the serialiser.
   assign take = word_valid && (!burst.has_result || can_load);
   assign load = take && burst.has_result;

   utf8c_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .take       (take),
      .word_valid (word_valid),
      .word       (word)
   );

   utf8c_process u_process (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .word  (word),
      .burst (burst)
   );

   utf8c_output_stage u_output (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .burst    (burst),
      .can_load (can_load),
      .rsp      (rsp_chan)
   );
endmodule

`default_nettype wire

### tb/sv/tb_utf8_codec.sv
// ----------------------------------------------------------------------------
// tb_utf8_codec: self-checking testbench of the UTF-8 codec
// A short table of directed words covers the range limits of every encoded
// length, out-of-range points and each decoder error. It is followed by
// random code points and byte strings, most of them well formed. Every result
// word is typed in or predicted by a behavioural model, and compared in order.
// Both channels idle at random, the result side once holds off for a long
// stretch, and the request side once pauses until all results are in.
// ----------------------------------------------------------------------------
module tb_utf8_codec;
   import utf8c_pkg::*;

   localparam int RANDOM_ITEMS  = 190;
   localparam int HOLD_CYCLES   = 60;
   localparam int SETTLE_CYCLES = 10;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int REPORT_LIMIT  = 10;

   // One word on the result channel.
   typedef struct packed {
      logic [7:0]  out_byte;
      logic [20:0] point;
      logic        error;
      logic        last;
   } rsp_word_type;

   // One row of the directed table; want holds a typed-in result, if any.
   typedef struct {
      req_word_type word;
      bit           has_want;
      rsp_word_type want;
   } plan_row_type;

   localparam rsp_word_type ERR_WORD = '{8'h00, 21'h000000, 1'b1, 1'b1};
   localparam rsp_word_type NO_WANT  = '0;

   localparam logic [20:0] BOUNDARY_POINTS [8] = '{
      21'h000000, 21'h00007F, 21'h000080, 21'h0007FF,
      21'h000800, 21'h00FFFF, 21'h010000, 21'h10FFFF
   };

   // Directed words: range limits, out-of-range points and decoder errors.
   plan_row_type directed_plan [27] = '{
      '{'{FUNC_DECODE, 21'h000000, 8'h41, 1'b0, 1'b0}, 1'b0, NO_WANT},
      '{'{FUNC_ENCODE, 21'h000000, 8'h00, 1'b0, 1'b0}, 1'b1, '{8'h00, 21'h0, 1'b0, 1'b1}},
      '{'{FUNC_ENCODE, 21'h00007F, 8'hFF, 1'b1, 1'b1}, 1'b1, '{8'h7F, 21'h0, 1'b0, 1'b1}},
      '{'{FUNC_ENCODE, 21'h000080, 8'h00, 1'b0, 1'b0}, 1'b0, NO_WANT},
      '{'{FUNC_ENCODE, 21'h0007FF, 8'h00, 1'b0, 1'b0}, 1'b0, NO_WANT},
      '{'{FUNC_ENCODE, 21'h000800, 8'h00, 1'b0, 1'b0}, 1'b0, NO_WANT},
      '{'{FUNC_ENCODE, 21'h00FFFF, 8'h00, 1'b0, 1'b0}, 1'b0, NO_WANT},
      '{'{FUNC_ENCODE, 21'h010000, 8'h00, 1'b0, 1'b0}, 1'b0, NO_WANT},
      '{'{FUNC_ENCODE, 21'h10FFFF, 8'h00, 1'b0, 1'b0}, 1'b0, NO_WANT},
      '{'{FUNC_ENCODE, 21'h110000, 8'h00, 1'b0, 1'b0}, 1'b1, ERR_WORD},
      '{'{FUNC_ENCODE, 21'h1FFFFF, 8'h00, 1'b0, 1'b0}, 1'b1, ERR_WORD},
      '{'{FUNC_DECODE, 21'h1FFFFF, 8'h00, 1'b1, 1'b1}, 1'b1, '{8'h00, 21'h0, 1'b0, 1'b1}},
      '{'{FUNC_DECODE, 21'h000000, 8'hFF, 1'b1, 1'b0}, 1'b1, ERR_WORD},
      '{'{FUNC_DECODE, 21'h000000, 8'h80, 1'b1, 1'b0}, 1'b1, ERR_WORD},
      '{'{FUNC_DECODE, 21'h000000, 8'hC3, 1'b1, 1'b1}, 1'b1, ERR_WORD},
      '{'{FUNC_DECODE, 21'h000000, 8'hF4, 1'b1, 1'b0}, 1'b0, NO_WANT},
      '{'{FUNC_DECODE, 21'h000000, 8'h8F, 1'b0, 1'b0}, 1'b0, NO_WANT},
      '{'{FUNC_DECODE, 21'h000000, 8'hBF, 1'b0, 1'b0}, 1'b0, NO_WANT},
      '{'{FUNC_DECODE, 21'h000000, 8'hBF, 1'b0, 1'b1}, 1'b0, NO_WANT},
      '{'{FUNC_DECODE, 21'h000000, 8'h41, 1'b0, 1'b0}, 1'b0, NO_WANT},
      '{'{FUNC_DECODE, 21'h000000, 8'hE2, 1'b1, 1'b0}, 1'b0, NO_WANT},
      '{'{FUNC_ENCODE, 21'h000041, 8'h00, 1'b0, 1'b0}, 1'b1, '{8'h41, 21'h0, 1'b0, 1'b1}},
      '{'{FUNC_DECODE, 21'h000000, 8'h41, 1'b0, 1'b0}, 1'b1, ERR_WORD},
      '{'{FUNC_DECODE, 21'h000000, 8'hC3, 1'b1, 1'b0}, 1'b0, NO_WANT},
      '{'{FUNC_DECODE, 21'h000000, 8'h7F, 1'b1, 1'b1}, 1'b1, '{8'h00, 21'h7F, 1'b0, 1'b1}},
      '{'{FUNC_DECODE, 21'h000000, 8'hE2, 1'b1, 1'b0}, 1'b0, NO_WANT},
      '{'{FUNC_DECODE, 21'h000000, 8'h82, 1'b0, 1'b1}, 1'b1, ERR_WORD}
   };

   logic clock = 1'b0;
   logic reset;

   utf8c_req_if req_if ();
   utf8c_rsp_if rsp_if ();

   utf8_codec u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Decoder state as predicted, starting with no character in progress.
   logic [1:0]  dec_left = 2'd0;
   logic [20:0] dec_acc  = 21'h0;
   logic        dec_idle = 1'b1;

   logic [7:0]   utf8_buf [4];
   rsp_word_type pred_words [$];
   rsp_word_type rsp_due [$];
   int           fault_count   = 0;
   int           work_items    = 0;
   int           gap_ahead     = 0;
   bit           calm          = 1'b0;
   bit           rsp_long_hold = 1'b0;
   int unsigned  cycle_count;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_word_type rsp_word(input logic [7:0] b, input logic [20:0] p,
                                             input logic e, input logic l);
      return '{b, p, e, l};
   endfunction

   // Appends one word to the results predicted for the current request.
   function automatic void add_pred(input rsp_word_type w);
      pred_words.insert(pred_words.size(), w);
   endfunction

   // Appends one word to the results still due on the result channel.
   function automatic void add_due(input rsp_word_type w);
      rsp_due.insert(rsp_due.size(), w);
   endfunction

   // Splits a code point of at most MAX_POINT into its UTF-8 bytes.
   function automatic int utf8_pack(input logic [20:0] cp);
      if (cp <= LIMIT_ONE) begin
         utf8_buf[0] = cp[7:0];
         return 1;
      end
      if (cp <= LIMIT_TWO) begin
         utf8_buf[0] = {LEAD_TWO, cp[10:6]};
         utf8_buf[1] = {CONT_MARK, cp[5:0]};
         return 2;
      end
      if (cp <= LIMIT_THREE) begin
         utf8_buf[0] = {LEAD_THREE, cp[15:12]};
         utf8_buf[1] = {CONT_MARK, cp[11:6]};
         utf8_buf[2] = {CONT_MARK, cp[5:0]};
         return 3;
      end
      utf8_buf[0] = {LEAD_FOUR, cp[20:18]};
      utf8_buf[1] = {CONT_MARK, cp[17:12]};
      utf8_buf[2] = {CONT_MARK, cp[11:6]};
      utf8_buf[3] = {CONT_MARK, cp[5:0]};
      return 4;
   endfunction

   // Ends the character in progress with an error word.
   function automatic void decode_fault();
      dec_idle = 1'b1;
      dec_left = 2'd0;
      add_pred(ERR_WORD);
   endfunction

   // Works out the result words of one request word and steps the decoder.
   function automatic void codec_predict(input req_word_type w);
      int         n;
      logic [1:0] more;
      bit         bad;
      pred_words.delete();
      more = 2'd0;
      bad  = 1'b0;
      if (w.func == FUNC_ENCODE) begin
         if (w.code_point > MAX_POINT) begin
            add_pred(ERR_WORD);
         end else begin
            n = utf8_pack(w.code_point);
            for (int i = 0; i < n; i++)
               add_pred(rsp_word(utf8_buf[i], 21'h0, 1'b0, i == n - 1));
         end
      end else if (w.string_start) begin
         // A string start drops any character in progress and reads a lead byte.
         if (!w.in_byte[7]) begin
            dec_idle = 1'b1;
            dec_left = 2'd0;
            dec_acc  = {13'h0, w.in_byte};
            add_pred(rsp_word(8'h00, dec_acc, 1'b0, 1'b1));
         end else begin
            if (w.in_byte[7:5] == LEAD_TWO) begin
               more    = 2'd1;
               dec_acc = {16'h0, w.in_byte[4:0]};
            end else if (w.in_byte[7:4] == LEAD_THREE) begin
               more    = 2'd2;
               dec_acc = {17'h0, w.in_byte[3:0]};
            end else if (w.in_byte[7:3] == LEAD_FOUR) begin
               more    = 2'd3;
               dec_acc = {18'h0, w.in_byte[2:0]};
            end else begin
               bad = 1'b1;
            end
            if (bad) begin
               decode_fault();
            end else begin
               dec_left = more;
               dec_idle = 1'b0;
               if (w.string_end)
                  decode_fault();
            end
         end
      end else if (!dec_idle) begin
         // Continuation bytes add six bits each until the character is whole.
         if (w.in_byte[7:6] != CONT_MARK) begin
            decode_fault();
         end else begin
            dec_acc  = {dec_acc[14:0], w.in_byte[5:0]};
            dec_left = dec_left - 2'd1;
            if (dec_left == 2'd0) begin
               dec_idle = 1'b1;
               add_pred(rsp_word(8'h00, dec_acc, 1'b0, 1'b1));
            end else if (w.string_end) begin
               decode_fault();
            end
         end
      end
   endfunction

   function automatic logic [20:0] random_point(input bit allow_bad);
      case ($urandom_range(0, allow_bad ? 6 : 4))
         0: return 21'($urandom_range(0, 'h7F));
         1: return 21'($urandom_range('h80, 'h7FF));
         2: return 21'($urandom_range('h800, 'hFFFF));
         3: return 21'($urandom_range('h10000, 'h10FFFF));
         4: return BOUNDARY_POINTS[$urandom_range(0, 7)];
         5: return 21'($urandom_range('h110000, 'h1FFFFF));
         default: return 21'($urandom());
      endcase
   endfunction

   function automatic void report_fault(input string what, input rsp_word_type want,
                                        input rsp_word_type seen);
      fault_count++;
      if (fault_count <= REPORT_LIMIT)
         $display("%0t %s: expected byte %02h point %06h error %0d last %0d, %s",
                  $realtime, what, want.out_byte, want.point, want.error, want.last,
                  $sformatf("got byte %02h point %06h error %0d last %0d",
                            seen.out_byte, seen.point, seen.error, seen.last));
   endfunction

   // Offers one request word after the gap drawn at the previous word, and
   // records its expected results once it is taken. Called at a falling edge.
   task automatic drive_word(input req_word_type w, input bit has_want,
                             input rsp_word_type want);
      repeat (gap_ahead) @(negedge clock);
      req_if.valid        <= 1'b1;
      req_if.func         <= w.func;
      req_if.code_point   <= w.code_point;
      req_if.in_byte      <= w.in_byte;
      req_if.string_start <= w.string_start;
      req_if.string_end   <= w.string_end;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      // Bytes that the decoder merely ignores are not counted as work.
      if (w.func == FUNC_ENCODE || w.string_start || !dec_idle)
         work_items++;
      codec_predict(w);
      if (has_want) begin
         add_due(want);
      end else begin
         foreach (pred_words[i])
            add_due(pred_words[i]);
      end
      @(negedge clock);
      gap_ahead = calm ? 0 : $urandom_range(0, 5);
      if (gap_ahead > 0)
         req_if.valid <= 1'b0;
   endtask

   task automatic send_encode(input logic [20:0] cp);
      req_word_type w;
      w = '{FUNC_ENCODE, cp, 8'($urandom()), 1'($urandom()), 1'($urandom())};
      drive_word(w, 1'b0, NO_WANT);
   endtask

   task automatic send_decode(input logic [7:0] b, input bit s, input bit e);
      req_word_type w;
      w = '{FUNC_DECODE, 21'($urandom()), b, s, e};
      drive_word(w, 1'b0, NO_WANT);
   endtask

   // Stops offering words and waits until every expected result has come.
   task automatic wait_drained();
      if (gap_ahead == 0)
         req_if.valid <= 1'b0;
      gap_ahead = 0;
      do @(negedge clock); while (rsp_due.size() != 0);
   endtask

   // Request side: directed table, then random code points and strings.
   initial begin : stimulus
      logic [7:0] str [$];
      logic [7:0] b;
      int         kind;
      int         n;
      int         flaw;
      int         pos;
      int         restart_at;
      bit         hold_done;
      bit         drain_done;
      hold_done  = 1'b0;
      drain_done = 1'b0;
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.func         <= FUNC_ENCODE;
      req_if.code_point   <= '0;
      req_if.in_byte      <= '0;
      req_if.string_start <= 1'b0;
      req_if.string_end   <= 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i])
         drive_word(directed_plan[i].word, directed_plan[i].has_want, directed_plan[i].want);
      wait_drained();
      work_items = 0;

      while (work_items < RANDOM_ITEMS) begin
         // Now and then switch into or out of a stretch with no idling on either side.
         if ($urandom_range(0, 7) == 0)
            calm = !calm;
         if (!hold_done && work_items >= 80) begin
            rsp_long_hold = 1'b1;
            hold_done     = 1'b1;
         end
         if (!drain_done && work_items >= 160) begin
            wait_drained();
            drain_done = 1'b1;
         end
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            send_encode(random_point(1'b1));
         end else if (kind < 90) begin
            // One string, well formed unless a flaw is put into it.
            str.delete();
            n = utf8_pack(random_point(1'b0));
            for (int i = 0; i < n; i++)
               str.insert(str.size(), utf8_buf[i]);
            restart_at = 0;
            if (kind >= 75) begin
               flaw = $urandom_range(0, 2);
               if (flaw == 0) begin
                  // Spoil the lead byte or one continuation byte.
                  pos = $urandom_range(0, n - 1);
                  b   = 8'($urandom());
                  if (pos == 0)
                     b = $urandom_range(0, 1) ? {2'b10, b[5:0]} : {5'b11111, b[2:0]};
                  else if (b[7:6] == CONT_MARK)
                     b[6] = 1'b1;
                  str[pos] = b;
               end else begin
                  // Cut the character short, and maybe start a new one.
                  if (n > 1)
                     repeat ($urandom_range(1, n - 1)) void'(str.pop_back());
                  if (flaw == 2) begin
                     restart_at = str.size();
                     n = utf8_pack(random_point(1'b0));
                     for (int i = 0; i < n; i++)
                        str.insert(str.size(), utf8_buf[i]);
                  end
               end
            end
            // Trailing bytes after the first character.
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 2)) str.insert(str.size(), 8'($urandom()));
            foreach (str[i]) begin
               if ($urandom_range(0, 15) == 0)
                  send_encode(random_point(1'b1));
               send_decode(str[i], i == 0 || i == restart_at, i == str.size() - 1);
            end
         end else begin
            repeat ($urandom_range(1, 3))
               send_decode(8'($urandom()), 1'($urandom()), 1'($urandom()));
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0 && rsp_due.size() == 0) begin
         $display("tb_utf8_codec passed");
      end else begin
         $display("tb_utf8_codec failed");
      end
      $finish;
   end

   // Result side: a random stall before each word, once a long hold-off.
   initial begin : rsp_sink
      int stall;
      rsp_if.ready <= 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_long_hold) begin
            stall         = HOLD_CYCLES;
            rsp_long_hold = 1'b0;
         end else begin
            stall = calm ? 0 : $urandom_range(0, 5);
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
         @(negedge clock);
      end
   end

   // Each accepted result word is compared with the oldest one due.
   always @(posedge clock) begin : rsp_check
      rsp_word_type seen;
      rsp_word_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         seen = rsp_word(rsp_if.out_byte, rsp_if.decoded_point, rsp_if.error, rsp_if.last);
         if (rsp_due.size() == 0) begin
            report_fault("word with none due", NO_WANT, seen);
         end else begin
            want = rsp_due.pop_front();
            if (seen.out_byte !== want.out_byte || seen.point !== want.point ||
                seen.error !== want.error || seen.last !== want.last)
               report_fault("word differs", want, seen);
         end
      end
   end

   // Ends a run that hangs.
   initial begin : watchdog
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
         @(posedge clock);
      $display("tb_utf8_codec failed");
      $finish;
   end

endmodule

### files.f
sv/utf8c_pkg.sv
sv/utf8c_req_if.sv
sv/utf8c_rsp_if.sv
sv/utf8c_input_stage.sv
sv/utf8c_process.sv
sv/utf8c_output_stage.sv
sv/utf8_codec.sv
tb/sv/tb_utf8_codec.sv
